// ===== src/nearest_palette_color_search_assert.svh =====
// Assertion macros used by the nearest palette color search top level.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define NPCS_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nearest palette search: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define NPCS_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nearest palette search: next-cycle check failed");

`endif

// ===== src/npcs_pkg.sv =====
// Package with types, constants and the distance function of the palette search.
`timescale 1ns / 1ps
package npcs_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int IDX_W   = 8;
	localparam int COLOR_W = 15;
	localparam int ERR_W   = 10;
	localparam int BEST_W  = ERR_W + 1;
	localparam logic [BEST_W-1:0] ERROR_START = 11'd1024;
	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(PALETTE_ENTRIES - 1);

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_SEARCH = 1'b1
	} cmd_e_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_LAST
	} state_t;

	typedef struct packed {
		logic               cmd;
		logic [IDX_W-1:0]   entry_index;
		logic [COLOR_W-1:0] color;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] best_index;
		logic [ERR_W-1:0] best_error;
	} rsp_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

	function automatic logic [7:0] abs_diff(logic [7:0] a, logic [7:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// Each 5-bit channel is moved to 8-bit alignment before the differences.
	function automatic logic [ERR_W-1:0] color_distance(logic [COLOR_W-1:0] q,
			logic [COLOR_W-1:0] e);
		logic [7:0] dr;
		logic [7:0] dg;
		logic [7:0] db;
		dr = abs_diff({q[4:0], 3'b000}, {e[4:0], 3'b000});
		dg = abs_diff({q[9:5], 3'b000}, {e[9:5], 3'b000});
		db = abs_diff({q[14:10], 3'b000}, {e[14:10], 3'b000});
		return ERR_W'(dr) + ERR_W'(dg) + ERR_W'(db);
	endfunction

endpackage

// ===== src/npcs_cell.sv =====
// One palette entry of the rotating cell ring.
`timescale 1ns / 1ps
module npcs_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  npcs_pkg::cell_ctrl_t         ctrl,
	input  logic [npcs_pkg::COLOR_W-1:0] wr_color,
	input  logic [npcs_pkg::COLOR_W-1:0] shift_in,
	output logic [npcs_pkg::COLOR_W-1:0] entry
);

	logic [npcs_pkg::COLOR_W-1:0] entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctrl.load) begin
			entry_q <= wr_color;
		end else if (ctrl.shift) begin
			entry_q <= shift_in;
		end
	end

	assign entry = entry_q;

endmodule

// ===== src/npcs_match.sv =====
// Distance stage and running minimum fed by the head of the cell ring.
`timescale 1ns / 1ps
module npcs_match (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         clear,
	input  logic                         head_vld,
	input  logic [npcs_pkg::IDX_W-1:0]   head_idx,
	input  logic [npcs_pkg::COLOR_W-1:0] head_color,
	input  logic [npcs_pkg::COLOR_W-1:0] query,
	output logic [npcs_pkg::IDX_W-1:0]   best_idx,
	output logic [npcs_pkg::BEST_W-1:0]  best_err
);

	logic                        vld_s1;
	logic [npcs_pkg::ERR_W-1:0]  dist_s1;
	logic [npcs_pkg::IDX_W-1:0]  idx_s1;
	logic [npcs_pkg::BEST_W-1:0] best_err_q;
	logic [npcs_pkg::IDX_W-1:0]  best_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= head_vld;
		end
	end

	always_ff @(posedge clk) begin
		dist_s1 <= npcs_pkg::color_distance(query, head_color);
		idx_s1  <= head_idx;
	end

	// Strict compare keeps the lowest index on a tie.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_err_q <= npcs_pkg::ERROR_START;
			best_idx_q <= '0;
		end else if (clear) begin
			best_err_q <= npcs_pkg::ERROR_START;
			best_idx_q <= '0;
		end else if (vld_s1 && ({1'b0, dist_s1} < best_err_q)) begin
			best_err_q <= {1'b0, dist_s1};
			best_idx_q <= idx_s1;
		end
	end

	assign best_idx = best_idx_q;
	assign best_err = best_err_q;

endmodule

// ===== src/nearest_palette_color_search.sv =====
// Top level of the nearest palette color search: control, cell ring and result.
`timescale 1ns / 1ps
`include "nearest_palette_color_search_assert.svh"

// A request is taken when start is high while busy is low. A write request
// stores its RGB555 color at entry_index and returns nothing; busy stays
// low, so the next request can follow right away. A search request raises
// busy and rotates the palette ring once around, one entry per cycle, past
// a single distance unit at the head of the ring; entries 1 and up are
// scored by the sum of absolute channel differences at 8-bit alignment. The
// full walk through the ring is followed by the distance register, the last
// compare and the result register. The result appears on the result port
// with done high for exactly one cycle; the receiver cannot stall it and
// must take it then. The palette is all zero after reset, and a search
// always returns an index of at least one.
module nearest_palette_color_search (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  npcs_pkg::req_t req,
	output logic           done,
	output npcs_pkg::rsp_t result
);

	localparam int N = npcs_pkg::PALETTE_ENTRIES;

	npcs_pkg::state_t state_q;
	npcs_pkg::state_t state_next;

	logic [npcs_pkg::IDX_W-1:0]   step_q;
	logic [npcs_pkg::COLOR_W-1:0] query_q;
	logic                         done_q;
	npcs_pkg::rsp_t               result_q;

	logic accept;
	logic wr_en;
	logic search_go;
	logic scanning;

	logic [npcs_pkg::COLOR_W-1:0] entries [N];
	logic [npcs_pkg::IDX_W-1:0]   best_idx;
	logic [npcs_pkg::BEST_W-1:0]  best_err;

	assign accept    = start && !busy;
	assign scanning  = (state_q == npcs_pkg::ST_SCAN);
	assign search_go = accept && (req.cmd == npcs_pkg::CMD_SEARCH);
	// Writes past the configured depth are dropped.
	assign wr_en = accept && (req.cmd == npcs_pkg::CMD_WRITE) &&
		({1'b0, req.entry_index} < (npcs_pkg::IDX_W + 1)'(N));

	// The ring: each cell takes its upper neighbor's entry while scanning, so
	// cell zero shows entry k at step k. After N shifts every entry is home
	// again, which is where writes find them.
	for (genvar i = 0; i < N; i++) begin : g_cell
		npcs_pkg::cell_ctrl_t ctrl;

		assign ctrl.shift = scanning;
		assign ctrl.load  = wr_en && (req.entry_index == npcs_pkg::IDX_W'(i));

		npcs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.wr_color (req.color),
			.shift_in (entries[(i + 1) % N]),
			.entry    (entries[i])
		);
	end

	// Entry zero passes the head first and is never scored.
	npcs_match u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (search_go),
		.head_vld   (scanning && (step_q != '0)),
		.head_idx   (step_q),
		.head_color (entries[0]),
		.query      (query_q),
		.best_idx   (best_idx),
		.best_err   (best_err)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= npcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Scan up to LAST_STEP, then ST_DRAIN for the last compare and ST_LAST to register.
	always_comb begin
		state_next = state_q;
		case (state_q)
			npcs_pkg::ST_IDLE: begin
				if (search_go) begin
					state_next = npcs_pkg::ST_SCAN;
				end
			end
			npcs_pkg::ST_SCAN: begin
				if (step_q == npcs_pkg::LAST_STEP) begin
					state_next = npcs_pkg::ST_DRAIN;
				end
			end
			npcs_pkg::ST_DRAIN: begin
				state_next = npcs_pkg::ST_LAST;
			end
			npcs_pkg::ST_LAST: begin
				state_next = npcs_pkg::ST_IDLE;
			end
			default: begin
				state_next = npcs_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != npcs_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (search_go) begin
				step_q <= '0;
			end else if (scanning) begin
				step_q <= step_q + 1'b1;
			end
			done_q <= (state_q == npcs_pkg::ST_LAST);
		end
	end

	always_ff @(posedge clk) begin
		if (search_go) begin
			query_q <= req.color;
		end
		if (state_q == npcs_pkg::ST_LAST) begin
			result_q.best_index <= best_idx;
			result_q.best_error <= best_err[npcs_pkg::ERR_W-1:0];
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`NPCS_ASSERT_IMP(a_done_when_idle, done, !busy)
	`NPCS_ASSERT_NXT(a_done_single, done, !done)
	`NPCS_ASSERT_NXT(a_last_gives_done, state_q == npcs_pkg::ST_LAST, done)
	`NPCS_ASSERT_NXT(a_search_goes_busy, search_go, busy && !done)
	`NPCS_ASSERT_IMP(a_index_nonzero, done, result.best_index != '0)

endmodule

// ===== tb/nearest_palette_color_search_tb.sv =====
// Self-checking testbench for the nearest palette color search block.
`timescale 1ns / 1ps

module nearest_palette_color_search_tb;
	import npcs_pkg::*;

	// A clean run's length is set mostly by its searches, about 900 of them,
	// plus the write requests and the idle gaps. The limit is set
	// several times above the worst case, where every request is a search
	// that also waits out the longest gap.
	localparam int unsigned CYCLE_LIMIT = 3_000_000;
	localparam int RANDOM_REQUESTS = 1930;
	// Cycles allowed for a search still in flight after the last request.
	localparam int SETTLE_CYCLES = PALETTE_ENTRIES + 40;

	// One planned request: its payload, the idle cycles before it is offered,
	// and whether it has to wait until every search has been answered.
	typedef struct {
		req_t        request;
		int unsigned idle_cycles;
		bit          wait_drain;
	} planned_request_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t result;

	planned_request_t pending_requests[$];
	rsp_t             expected_matches[$];
	logic [COLOR_W-1:0] palette_mirror[PALETTE_ENTRIES];
	logic [COLOR_W-1:0] recent_colors[$];

	// Both counters change by nonblocking assignment only, so the driver
	// reads them free of any ordering within a time step.
	int unsigned searches_issued;
	int unsigned searches_answered;
	int unsigned failure_count = 0;
	int unsigned cycle_count = 0;

	// Driver state; only the driver process writes these.
	planned_request_t staged_request;
	bit               have_staged = 1'b0;
	int unsigned      idle_left = 0;

	// Generator state: quiet phases offer requests back to back.
	bit quiet_phase = 1'b0;

	nearest_palette_color_search u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.result (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("nearest_palette_color_search_tb: errors");
			$finish;
		end
	end

	task automatic log_failure(input string msg);
		failure_count++;
		if (failure_count <= 10) begin
			$display("%0t: %s", $realtime, msg);
		end
	endtask

	// Manhattan distance between two RGB555 colors with every 5-bit channel
	// moved up to 8-bit alignment, so each channel spans 0 to 248.
	function automatic int unsigned scaled_distance(logic [COLOR_W-1:0] a,
			logic [COLOR_W-1:0] b);
		int unsigned total;
		int unsigned av;
		int unsigned bv;
		total = 0;
		for (int ch = 0; ch < 3; ch++) begin
			av = int'(a[ch*5 +: 5]) * 8;
			bv = int'(b[ch*5 +: 5]) * 8;
			total += (av > bv) ? (av - bv) : (bv - av);
		end
		return total;
	endfunction

	// Walks entries 1 and up of the mirrored palette. The strict compare keeps
	// the lowest index on a tie, and since no distance reaches 1024, entry one
	// is always taken first, so the index never comes back as zero.
	function automatic rsp_t nearest_entry(logic [COLOR_W-1:0] query);
		rsp_t        found;
		int unsigned score;
		int unsigned lowest;
		found = '0;
		lowest = 1024;
		for (int n = 1; n < PALETTE_ENTRIES; n++) begin
			score = scaled_distance(query, palette_mirror[n]);
			if (score < lowest) begin
				lowest = score;
				found.best_index = IDX_W'(n);
			end
		end
		found.best_error = ERR_W'(lowest);
		return found;
	endfunction

	// Updates the mirrored palette for an accepted write, or queues the
	// expected answer for an accepted search. Every index of the 8-bit field
	// lies inside a full 256-entry palette, so no write is dropped.
	task automatic apply_request(input req_t r);
		if (r.cmd == CMD_WRITE) begin
			palette_mirror[r.entry_index] = r.color;
		end else begin
			expected_matches.push_back(nearest_entry(r.color));
		end
	endtask

	task automatic queue_request(input cmd_e_t cmd, input logic [IDX_W-1:0] index,
			input logic [COLOR_W-1:0] color, input bit wait_drain);
		planned_request_t item;
		item.request.cmd = cmd;
		item.request.entry_index = index;
		item.request.color = color;
		item.idle_cycles = quiet_phase ? 0 : $urandom_range(0, 7);
		item.wait_drain = wait_drain;
		pending_requests.push_back(item);
	endtask

	// Driver. A request counts as taken at an edge where start is high and
	// busy is low. Start is held while busy; otherwise the next staged
	// request first waits out its idle cycles and, where marked, until every
	// search in flight has been answered. Start gets at most one assignment per edge.
	always @(posedge clk or negedge arst_n) begin
		logic        taken;
		int unsigned open_searches;
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			searches_issued <= 0;
			have_staged = 1'b0;
			idle_left = 0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				apply_request(req);
			end
			if (taken && req.cmd == CMD_SEARCH) begin
				searches_issued <= searches_issued + 1;
			end
			// The answer counter may not yet count an answer given at this edge, which
			// only makes a drain pause longer.
			open_searches = searches_issued - searches_answered
				+ ((taken && req.cmd == CMD_SEARCH) ? 1 : 0);
			if (!(start && !taken)) begin
				if (!have_staged && pending_requests.size() != 0) begin
					staged_request = pending_requests.pop_front();
					have_staged = 1'b1;
					idle_left = staged_request.idle_cycles;
				end
				if (have_staged && idle_left != 0) begin
					idle_left--;
					start <= 1'b0;
				end else if (have_staged && !(staged_request.wait_drain && open_searches != 0)) begin
					req <= staged_request.request;
					start <= 1'b1;
					have_staged = 1'b0;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor. A result is valid for the single cycle that done is high, and
	// it is matched against the oldest outstanding search.
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			searches_answered <= 0;
		end else if (done) begin
			searches_answered <= searches_answered + 1;
			if (expected_matches.size() == 0) begin
				log_failure($sformatf("result with no search waiting: index %0d error %0d",
					result.best_index, result.best_error));
			end else begin
				want = expected_matches.pop_front();
				if (result.best_index !== want.best_index) begin
					log_failure($sformatf("best_index: expected %0d, got %0d",
						want.best_index, result.best_index));
				end
				if (result.best_error !== want.best_error) begin
					log_failure($sformatf("best_error: expected %0d, got %0d",
						want.best_error, result.best_error));
				end
			end
		end
	end

	initial begin
		int unsigned      pick;
		logic [IDX_W-1:0] index;
		logic [COLOR_W-1:0] color;
		bit               drain;

		foreach (palette_mirror[i]) begin
			palette_mirror[i] = '0;
		end

		// Directed part. The palette is all zero after reset, so the first
		// searches land on entry one: zero distance for black, the largest
		// possible distance of 744 for white.
		queue_request(CMD_SEARCH, 8'h00, 15'h0000, 1'b0);
		queue_request(CMD_SEARCH, 8'hFF, 15'h7FFF, 1'b0);
		// Entry zero is stored but never searched, so white still maps to
		// entry one at full distance.
		queue_request(CMD_WRITE, 8'h00, 15'h7FFF, 1'b1);
		queue_request(CMD_SEARCH, 8'h00, 15'h7FFF, 1'b0);
		// An exact hit in the last entry, then a tie that the lower entry wins.
		queue_request(CMD_WRITE, 8'hFF, 15'h7FFF, 1'b0);
		queue_request(CMD_SEARCH, 8'h5A, 15'h7FFF, 1'b0);
		queue_request(CMD_WRITE, 8'd200, 15'h7FFF, 1'b0);
		queue_request(CMD_SEARCH, 8'hA5, 15'h7FFF, 1'b0);
		// One saturated channel per entry, each found by its own query.
		queue_request(CMD_WRITE, 8'd1, 15'h001F, 1'b0);
		queue_request(CMD_WRITE, 8'd2, 15'h03E0, 1'b0);
		queue_request(CMD_WRITE, 8'd3, 15'h7C00, 1'b0);
		queue_request(CMD_SEARCH, 8'h00, 15'h001F, 1'b0);
		queue_request(CMD_SEARCH, 8'h00, 15'h03E0, 1'b0);
		queue_request(CMD_SEARCH, 8'h00, 15'h7C00, 1'b1);
		// A query nearest gray entry five, then a white tie the lower entry wins.
		queue_request(CMD_WRITE, 8'd4, 15'h0421, 1'b0);
		queue_request(CMD_WRITE, 8'd5, 15'h0842, 1'b0);
		queue_request(CMD_SEARCH, 8'h00, 15'h0631, 1'b0);
		queue_request(CMD_SEARCH, 8'h00, 15'h5294, 1'b0);
		queue_request(CMD_WRITE, 8'd128, 15'h2AAA, 1'b0);
		queue_request(CMD_WRITE, 8'd127, 15'h5555, 1'b0);
		queue_request(CMD_SEARCH, 8'hFF, 15'h2AAA, 1'b0);
		queue_request(CMD_SEARCH, 8'h00, 15'h5555, 1'b0);

		// Random part: a little over half writes, so the palette keeps
		// changing, and searches that often aim at or next to a stored color.
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i % 64 == 0) begin
				quiet_phase = ($urandom_range(0, 3) == 0);
			end
			drain = (i % 150 == 149);
			if ($urandom_range(0, 99) < 55) begin
				pick = $urandom_range(0, 9);
				index = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : IDX_W'($urandom_range(0, 255));
				pick = $urandom_range(0, 15);
				color = (pick == 0) ? 15'h0000 : (pick == 1) ? 15'h7FFF
					: COLOR_W'($urandom_range(0, 32767));
				recent_colors.push_back(color);
				if (recent_colors.size() > 64) begin
					void'(recent_colors.pop_front());
				end
				queue_request(CMD_WRITE, index, color, drain);
			end else begin
				pick = $urandom_range(0, 9);
				color = COLOR_W'($urandom_range(0, 32767));
				if (pick < 5 && recent_colors.size() != 0) begin
					color = recent_colors[$urandom_range(0, recent_colors.size() - 1)];
					// Sometimes nudge one bit so the hit is close, not exact.
					if (pick < 2) begin
						color[$urandom_range(0, COLOR_W - 1)] ^= 1'b1;
					end
				end else if (pick == 9) begin
					color = ($urandom_range(0, 1) == 0) ? 15'h0000 : 15'h7FFF;
				end
				queue_request(CMD_SEARCH, IDX_W'($urandom_range(0, 255)), color, drain);
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Sampling on the falling edge keeps these checks clear of the
		// processes that run at the rising edge.
		while (pending_requests.size() != 0 || have_staged || start
				|| expected_matches.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);

		while (expected_matches.size() != 0) begin
			log_failure($sformatf("search never answered: expected index %0d error %0d",
				expected_matches[0].best_index, expected_matches[0].best_error));
			void'(expected_matches.pop_front());
		end

		if (failure_count == 0) begin
			$display("nearest_palette_color_search_tb: clean");
		end else begin
			$display("nearest_palette_color_search_tb: errors");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/npcs_pkg.sv
src/npcs_cell.sv
src/npcs_match.sv
src/nearest_palette_color_search.sv
tb/nearest_palette_color_search_tb.sv
